### rtl/les_pkg.sv
// les_pkg: shared constants, types and helpers of the largest empty square finder.
// Depends on nothing; used by les_row_buf and largest_empty_square_finder.
package les_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int CHAR_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [SIZE_W-1:0] ROW_WIDTH_RST  = SIZE_W'(1024);
  localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = CHAR_W'(46);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH  = 1'b0,
    CFG_EMPTY_CHAR = 1'b1
  } cfg_idx_e;

  // write port of the previous-row store
  typedef struct packed {
    logic              en;
    logic [COL_W-1:0]  addr;
    logic [SIZE_W-1:0] data;
  } les_wr_t;

  function automatic logic [SIZE_W-1:0] min3(input logic [SIZE_W-1:0] a,
                                              input logic [SIZE_W-1:0] b,
                                              input logic [SIZE_W-1:0] c);
    logic [SIZE_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

### rtl/les_row_buf.sv
// les_row_buf: previous-row store, one write and one registered read per cycle.
// Same-cycle write to the read address is forwarded. Depends on les_pkg.
module les_row_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [les_pkg::COL_W-1:0]   rd_addr_i,
  input  les_pkg::les_wr_t            wr_i,
  output logic [les_pkg::SIZE_W-1:0]  up_o
);

  logic [les_pkg::SIZE_W-1:0] mem [les_pkg::MAX_WIDTH];
  logic [les_pkg::SIZE_W-1:0] rd_q;
  logic [les_pkg::SIZE_W-1:0] byp_data_q;
  logic                       byp_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (rd_en_i) begin
      byp_q <= wr_i.en && (wr_i.addr == rd_addr_i);
    end
  end

  assign up_o = byp_q ? byp_data_q : rd_q;

endmodule

### rtl/largest_empty_square_finder.sv
// largest_empty_square_finder: top level, maximal-square scan over a cell stream.
// Depends on les_pkg and les_row_buf.
// Throughput: one cell per cycle; only a last cell waits, while an earlier result is held.
// Result: a last cell passes the input register into the result register, waiting while an earlier result is held.
// Reset (async, active low): counters, neighbours and best square cleared, row_width 1024,
// empty_char 46; the row store is not cleared, the first row of a grid rewrites it.
module largest_empty_square_finder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [les_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [les_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // cell items
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [les_pkg::CHAR_W-1:0]      cell_char_i,
  input  logic                            last_cell_i,
  // result items
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [les_pkg::SIZE_W-1:0]      square_size_o,
  output logic [les_pkg::ROW_W-1:0]       corner_row_o,
  output logic [les_pkg::COL_W-1:0]       corner_col_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [les_pkg::SIZE_W-1:0] row_width_q;
  logic [les_pkg::CHAR_W-1:0] empty_char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q  <= les_pkg::ROW_WIDTH_RST;
      empty_char_q <= les_pkg::EMPTY_CHAR_RST;
    end else if (cfg_we_i) begin
      case (les_pkg::cfg_idx_e'(cfg_idx_i))
        les_pkg::CFG_ROW_WIDTH:  row_width_q  <= cfg_data_i[les_pkg::SIZE_W-1:0];
        les_pkg::CFG_EMPTY_CHAR: empty_char_q <= cfg_data_i[les_pkg::CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Width in use: zero acts as one, anything above the store depth is clamped.
  logic [les_pkg::COL_W:0] act_width;

  always_comb begin
    if (row_width_q == '0) begin
      act_width = (les_pkg::COL_W+1)'(1);
    end else if (row_width_q > les_pkg::SIZE_W'(les_pkg::MAX_WIDTH)) begin
      act_width = (les_pkg::COL_W+1)'(les_pkg::MAX_WIDTH);
    end else begin
      act_width = (les_pkg::COL_W+1)'(row_width_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: scan position. Counters move as a cell is taken, so the store
  // read for that cell can go out on the same edge.
  // ---------------------------------------------------------------------------
  logic                       in_acc;
  logic                       s0_adv;
  logic [les_pkg::COL_W-1:0]  col_count_q;
  logic [les_pkg::ROW_W-1:0]  row_count_q;
  logic                       row_end;
  logic                       row_sat;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign row_end = ({1'b0, col_count_q} + (les_pkg::COL_W+1)'(1)) >= act_width;
  assign row_sat = ({1'b0, row_count_q} + (les_pkg::ROW_W+1)'(1))
                   >= (les_pkg::ROW_W+1)'(les_pkg::MAX_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else if (in_acc) begin
      if (last_cell_i) begin
        // grid ends: next cell starts a fresh scan
        col_count_q <= '0;
        row_count_q <= '0;
      end else if (row_end) begin
        col_count_q <= '0;
        if (!row_sat) begin
          row_count_q <= row_count_q + les_pkg::ROW_W'(1);
        end
      end else begin
        col_count_q <= col_count_q + les_pkg::COL_W'(1);
      end
    end
  end

  // Input register
  logic                       s0_valid_q;
  logic [les_pkg::CHAR_W-1:0] s0_char_q;
  logic                       s0_last_q;
  logic [les_pkg::COL_W-1:0]  s0_col_q;
  logic [les_pkg::ROW_W-1:0]  s0_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_acc) begin
      s0_valid_q <= 1'b1;
    end else if (s0_adv) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_char_q <= cell_char_i;
      s0_last_q <= last_cell_i;
      s0_col_q  <= col_count_q;
      s0_row_q  <= row_count_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: square side for the held cell, store write-back, best square.
  // ---------------------------------------------------------------------------
  logic                       out_valid_q;
  logic [les_pkg::SIZE_W-1:0] up_val;
  logic [les_pkg::SIZE_W-1:0] left_q;
  logic [les_pkg::SIZE_W-1:0] diag_q;
  logic [les_pkg::SIZE_W-1:0] best_size_q;
  logic [les_pkg::ROW_W-1:0]  best_row_q;
  logic [les_pkg::COL_W-1:0]  best_col_q;
  logic [les_pkg::SIZE_W-1:0] side;
  logic                       is_empty;
  logic                       better;
  les_pkg::les_wr_t           wr;

  // only a last cell waits on the result register
  assign s0_adv     = s0_valid_q && (!s0_last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = s0_valid_q && !s0_adv;

  assign is_empty = (s0_char_q == empty_char_q);

  always_comb begin
    if (!is_empty) begin
      side = '0;
    end else if ((s0_col_q == '0) || (s0_row_q == '0)) begin
      side = les_pkg::SIZE_W'(1);
    end else begin
      side = les_pkg::min3(left_q, diag_q, up_val) + les_pkg::SIZE_W'(1);
    end
  end

  assign better = side > best_size_q;

  assign wr.en   = s0_adv;
  assign wr.addr = s0_col_q;
  assign wr.data = side;

  les_row_buf u_row_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_count_q),
    .wr_i      (wr),
    .up_o      (up_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q      <= '0;
      diag_q      <= '0;
      best_size_q <= '0;
      best_row_q  <= '0;
      best_col_q  <= '0;
    end else if (s0_adv) begin
      if (s0_last_q) begin
        left_q      <= '0;
        diag_q      <= '0;
        best_size_q <= '0;
        best_row_q  <= '0;
        best_col_q  <= '0;
      end else begin
        left_q <= side;
        diag_q <= up_val;
        if (better) begin
          best_size_q <= side;
          best_row_q  <= s0_row_q;
          best_col_q  <= s0_col_q;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                       out_acc;
  logic [les_pkg::SIZE_W-1:0] res_size_q;
  logic [les_pkg::ROW_W-1:0]  res_row_q;
  logic [les_pkg::COL_W-1:0]  res_col_q;

  assign out_acc = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s0_adv && s0_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_adv && s0_last_q) begin
      res_size_q <= better ? side     : best_size_q;
      res_row_q  <= better ? s0_row_q : best_row_q;
      res_col_q  <= better ? s0_col_q : best_col_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign square_size_o = res_size_q;
  assign corner_row_o  = res_row_q;
  assign corner_col_o  = res_col_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_needs_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s0_valid_q |-> !in_stall_o)
    else $error("input stalled with no cell held");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s0_adv && s0_last_q))
    else $error("result raised without a last cell");

  a_best_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_adv && s0_last_q) |=> (best_size_q == '0) && (left_q == '0))
    else $error("scan state not cleared after last cell");

  a_edge_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_valid_q && ((s0_col_q == '0) || (s0_row_q == '0)))
      |-> (side <= les_pkg::SIZE_W'(1)))
    else $error("edge cell square larger than one");

endmodule

### verif/testbench.sv
// Self-checking testbench for largest_empty_square_finder: a square scoreboard predicts each
// grid's best empty square from the accepted cells, and plain tasks drive the cell and result ports.
// Depends on les_pkg and the largest_empty_square_finder RTL only.
`timescale 1ns / 1ps

module testbench;
  import les_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2e;
  localparam logic [CHAR_W-1:0] HASH_CHAR = 8'h23;

  // one grid cell as offered on the input channel
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
  } cell_t;

  // best square of a finished grid, field order as on the result ports
  typedef struct packed {
    logic [SIZE_W-1:0] side;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } square_t;

  // Tracks the scan exactly as the block should: the previous row of square
  // sides, left and upper-left neighbours, position and best square so far.
  class square_scoreboard;
    logic [SIZE_W-1:0] width_reg;
    logic [CHAR_W-1:0] empty_reg;
    logic [SIZE_W-1:0] above_row [MAX_WIDTH];
    logic [SIZE_W-1:0] left_side;
    logic [SIZE_W-1:0] corner_side;
    int unsigned       col_pos;
    int unsigned       row_pos;
    square_t           best;
    square_t           expected_squares[$];
    int unsigned       mismatches;

    function new();
      width_reg = ROW_WIDTH_RST;
      empty_reg = EMPTY_CHAR_RST;
      foreach (above_row[i]) above_row[i] = '0;
      mismatches = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      left_side   = '0;
      corner_side = '0;
      col_pos     = 0;
      row_pos     = 0;
      best        = '0;
    endfunction

    // width 0 behaves as 1, anything past the store depth as the full depth
    function int unsigned span();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width_reg);
    endfunction

    function void apply_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ROW_WIDTH:  width_reg = data;
        CFG_EMPTY_CHAR: empty_reg = data[CHAR_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_squares.size();
    endfunction

    // note an accepted cell; a last cell queues the grid's best square
    function void take_cell(logic [CHAR_W-1:0] ch, logic is_last);
      logic [SIZE_W-1:0] up;
      logic [SIZE_W-1:0] least;
      logic [SIZE_W-1:0] side;
      up    = above_row[col_pos];
      least = (left_side < corner_side) ? left_side : corner_side;
      if (up < least) least = up;
      if (ch != empty_reg) side = '0;
      else if (col_pos == 0 || row_pos == 0) side = SIZE_W'(1);
      else side = least + SIZE_W'(1);
      // strictly larger only: ties keep the earliest corner
      if (side > best.side) begin
        best.side = side;
        best.row  = ROW_W'(row_pos);
        best.col  = COL_W'(col_pos);
      end
      corner_side        = up;
      above_row[col_pos] = side;
      left_side          = side;
      if (col_pos + 1 >= span()) begin
        col_pos = 0;
        if (row_pos + 1 < MAX_HEIGHT) row_pos++;
      end else begin
        col_pos++;
      end
      if (is_last) begin
        expected_squares.push_back(best);
        clear_scan();
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_square(square_t got);
      square_t want;
      if (expected_squares.size() == 0) begin
        report($sformatf("result side %0d at (%0d,%0d) with none expected",
                         got.side, got.row, got.col));
        return;
      end
      want = expected_squares.pop_front();
      if (got.side != want.side)
        report($sformatf("square_size %0d, expected %0d", got.side, want.side));
      if (got.row != want.row)
        report($sformatf("corner_row %0d, expected %0d", got.row, want.row));
      if (got.col != want.col)
        report($sformatf("corner_col %0d, expected %0d", got.col, want.col));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [CHAR_W-1:0]     cell_char_i = '0;
  logic                  last_cell_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [SIZE_W-1:0]     square_size_o;
  logic [ROW_W-1:0]      corner_row_o;
  logic [COL_W-1:0]      corner_col_o;

  square_scoreboard sb;
  cell_t            cell_q[$];
  int unsigned      send_idle_pct = 18;
  int unsigned      recv_idle_pct = 56;
  bit               hold_req      = 1'b0;
  bit               hold_begun    = 1'b0;
  int unsigned      hold_left     = 0;
  int unsigned      cycle_count   = 0;

  largest_empty_square_finder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cell_char_i   (cell_char_i),
    .last_cell_i   (last_cell_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .square_size_o (square_size_o),
    .corner_row_o  (corner_row_o),
    .corner_col_o  (corner_col_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // Result side. Ports are sampled before the edge's updates land, so a
  // result counts when valid was high and our stall low going into the edge.
  // The long hold-off, once requested, is counted down here in whole cycles.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_square({square_size_o, corner_row_o, corner_col_o});
    if (hold_req && !hold_begun) begin
      hold_begun = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function void push_cell(logic [CHAR_W-1:0] ch, logic is_last);
    cell_t c;
    c.ch      = ch;
    c.is_last = is_last;
    cell_q.push_back(c);
  endfunction

  // One grid of random content for the current width: mostly whole rows,
  // sometimes a ragged tail, now and then cut short. Returns its cell count.
  function automatic int unsigned push_random_grid(int unsigned span);
    int unsigned rows;
    int unsigned cells;
    int unsigned fill;
    logic [CHAR_W-1:0] ch;
    if (span <= 40) begin
      rows  = $urandom_range(1, span <= 4 ? 12 : (span <= 12 ? 6 : 3));
      cells = rows * span;
      if ($urandom_range(3) == 0) cells += $urandom_range(0, span - 1);
    end else begin
      // wide rows: keep to a part of the first row or two
      cells = $urandom_range(1, 60);
    end
    if ($urandom_range(9) == 0) cells = $urandom_range(1, cells);
    case ($urandom_range(4))
      0:       fill = 0;
      1:       fill = 50;
      2:       fill = 80;
      3:       fill = 95;
      default: fill = 100;
    endcase
    for (int unsigned i = 0; i < cells; i++) begin
      ch = ($urandom_range(99) < fill) ? sb.empty_reg : CHAR_W'($urandom_range(255));
      push_cell(ch, i == cells - 1);
    end
    return cells;
  endfunction

  // register write; the scoreboard takes the value at the same edge
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.apply_reg(idx, data);
  endtask

  // Offer the queued cells. A stalled item is held as it is; otherwise the
  // next one is offered or the line idles, one assignment per edge.
  task automatic send_cells();
    int unsigned taken;
    taken = 0;
    while (taken < cell_q.size()) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        sb.take_cell(cell_char_i, last_cell_i);
        taken++;
      end
      if (in_valid_i && in_stall_o) begin
        // held
      end else if (taken < cell_q.size() && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i  <= 1'b1;
        cell_char_i <= cell_q[taken].ch;
        last_cell_i <= cell_q[taken].is_last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    cell_q.delete();
  endtask

  // all squares in, then a settling wait for a cell that gives no result
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned random_cells;
    int unsigned wcfg;
    int unsigned r;
    bit          pressure_done;
    sb            = new();
    random_cells  = 0;
    pressure_done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    // Reset registers: blocked then empty on the first row.
    push_cell(HASH_CHAR, 1'b0);
    push_cell(DOT_CHAR, 1'b1);
    send_cells();
    settle();

    // Width 3, empty code 0, cell extremes 0 and 255; then a grid with
    // nothing empty, which must give a zero square at the origin.
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(3));
    write_reg(CFG_EMPTY_CHAR, CFG_DATA_W'(0));
    push_cell(8'h00, 1'b0);
    push_cell(8'h00, 1'b0);
    push_cell(8'hff, 1'b0);
    push_cell(8'h00, 1'b0);
    push_cell(8'h00, 1'b0);
    push_cell(8'h00, 1'b1);
    push_cell(8'hff, 1'b0);
    push_cell(8'hff, 1'b1);
    send_cells();
    settle();

    // Width 0 behaves as one column; empty code 255 with spare data bits set.
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(0));
    write_reg(CFG_EMPTY_CHAR, CFG_DATA_W'(11'h7ff));
    push_cell(8'hff, 1'b0);
    push_cell(8'hff, 1'b0);
    push_cell(8'h00, 1'b1);
    send_cells();
    settle();

    // Width beyond the store depth clamps to it.
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(2047));
    write_reg(CFG_EMPTY_CHAR, CFG_DATA_W'(DOT_CHAR));
    repeat (2) push_cell(DOT_CHAR, 1'b0);
    push_cell(DOT_CHAR, 1'b1);
    send_cells();
    settle();

    // Width narrowed in mid-row: the current column is already past the
    // new end, so the row closes on the next cell.
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(4));
    repeat (6) push_cell(DOT_CHAR, 1'b0);
    send_cells();
    settle();
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(2));
    repeat (2) push_cell(DOT_CHAR, 1'b0);
    push_cell(DOT_CHAR, 1'b1);
    send_cells();
    settle();

    // --- random ---
    while (random_cells < 725) begin
      if (random_cells >= 480) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_cells >= 240) begin
        send_idle_pct = 56;
        recv_idle_pct = 18;
      end

      // Back-pressure: results pile up behind a long stall while the
      // sender keeps offering tiny grids, until the input stalls too.
      if (!pressure_done && random_cells >= 480) begin
        pressure_done = 1'b1;
        write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(3));
        @(negedge clk_i);
        hold_req = 1'b1;
        repeat (80) begin
          r = $urandom_range(1, 2);
          for (int unsigned i = 0; i < r; i++)
            push_cell(($urandom_range(3) != 0) ? sb.empty_reg : CHAR_W'($urandom_range(255)),
                      i == r - 1);
          random_cells += r;
        end
        send_cells();
        settle();
      end

      r = $urandom_range(19);
      if (r == 0) wcfg = 0;
      else if (r == 1) wcfg = $urandom_range(1024, 2047);
      else if (r <= 5) wcfg = $urandom_range(13, 40);
      else wcfg = $urandom_range(1, 12);
      write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(wcfg));
      r = $urandom_range(7);
      write_reg(CFG_EMPTY_CHAR, {3'($urandom_range(7)),
                                 (r == 0) ? 8'h00 : (r == 1) ? 8'hff
                                          : CHAR_W'($urandom_range(255))});
      repeat ($urandom_range(1, 4)) random_cells += push_random_grid(sb.span());
      send_cells();
      settle();
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/les_pkg.sv
rtl/les_row_buf.sv
rtl/largest_empty_square_finder.sv
verif/testbench.sv
